>>> rtl/core/wpca_pkg.sv
package wpca_pkg;

	localparam int CAP_W = 16;

	localparam logic [1:0] OP_OVERFLOW = 2'd0;
	localparam logic [1:0] OP_CAPTURE  = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;

	localparam logic [15:0] OVF_RESET   = 16'hFFFF;
	localparam logic [31:0] STORE_RESET = 32'h0000_FFFF;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [1:0]       wheel;
		logic [CAP_W-1:0] capture_value;
		logic [6:0]       window_count;
	} in_item_t;

	typedef struct packed {
		logic [31:0] tick_total;
		logic [31:0] mean_period;
	} out_item_t;

endpackage

>>> rtl/core/wpca_ram.sv
module wpca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/wpca_div.sv
module wpca_div #(
	parameter int DVD_W = 36,
	parameter int DVS_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	// one quotient bit per cycle, dividend shifts out as quotient shifts in
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/core/wheel_period_capture_averager_unit.sv
// per-wheel hall sensor period meter
// an item is taken when start is high and busy is low. opcode overflow bumps the
// wheel's overflow count, capture stores overflow:capture_value as a period in the
// wheel's ring, bumps the tick count and advances the ring pointer, query returns
// the tick count and the truncated mean of the newest window_count periods
// (0 reads as 1, larger than HISTORY_DEPTH reads as HISTORY_DEPTH).
// a query gives exactly one result beat: done is high for one cycle with result
// valid; the receiver cannot stall, so the beat is gone after that cycle.
// events and items with an unused opcode or a wheel not below WHEELS give none.
// an event passes through a load step; a query then reads its window one ring entry per cycle
// and runs the bit-serial divider on the sum; busy stays high
// until the item is done, and the result beat comes with busy low again.
// per-wheel state sits in a small ram with a valid bit per wheel; ring entries
// beyond a wheel's fill count read as 0xffff, so no clearing pass is needed and
// the block takes items from the first cycle after reset.
module wheel_period_capture_averager_unit #(
	parameter int WHEELS        = 4,
	parameter int HISTORY_DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  wpca_pkg::in_item_t   item,
	output logic                 busy,
	output logic                 done,
	output wpca_pkg::out_item_t  result
);

	import wpca_pkg::*;

	localparam int WHL_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = 32 + CNT_W;
	localparam int PS_AW = WHL_W + IDX_W;
	localparam int PS_DEPTH = 1 << PS_AW;

	typedef struct packed {
		logic [31:0]      tick;
		logic [15:0]      ovf;
		logic [IDX_W-1:0] wp;
		logic [CNT_W-1:0] fill;
	} wstate_t;

	localparam int WS_W = $bits(wstate_t);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_SUM  = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

	state_t             st_q;
	logic [WHEELS-1:0]  ws_vld_q;
	in_item_t           item_q;
	logic               done_q;
	out_item_t          result_q;

	logic               accept;
	logic               item_ok;
	logic [WHL_W-1:0]   wsel;

	logic [WS_W-1:0]    ws_rdata;
	wstate_t            cur;
	wstate_t            ws_wdata;
	logic               ws_we;

	logic               ps_we;
	logic [PS_AW-1:0]   ps_waddr;
	logic [31:0]        ps_wdata;
	logic [PS_AW-1:0]   ps_raddr;
	logic [31:0]        ps_rdata;

	logic [CNT_W-1:0]   win_n;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   issue_cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   fill_q;
	logic [31:0]        tick_q;
	logic [SUM_W-1:0]   sum_q;
	logic               rd_vld_s1;
	logic               ent_ok_s1;
	logic               issue;
	logic               sum_end;
	logic               div_done;
	logic [SUM_W-1:0]   div_quo;

	assign accept  = start && (st_q == ST_IDLE);
	assign item_ok = (5'(item.wheel) < 5'(WHEELS)) &&
		((item.opcode == OP_OVERFLOW) || (item.opcode == OP_CAPTURE) ||
		(item.opcode == OP_QUERY));
	assign wsel    = WHL_W'(item_q.wheel);

	// wheels never written read as their reset state
	always_comb begin
		if (ws_vld_q[wsel]) begin
			cur = wstate_t'(ws_rdata);
		end else begin
			cur.tick = '0;
			cur.ovf  = OVF_RESET;
			cur.wp   = '0;
			cur.fill = '0;
		end
	end

	always_comb begin
		ws_wdata = cur;
		unique case (item_q.opcode)
			OP_OVERFLOW: begin
				ws_wdata.ovf = cur.ovf + 16'd1;
			end
			OP_CAPTURE: begin
				ws_wdata.tick = cur.tick + 32'd1;
				ws_wdata.ovf  = '0;
				ws_wdata.wp   = (cur.wp == IDX_W'(HISTORY_DEPTH - 1)) ? '0 :
					cur.wp + IDX_W'(1);
				ws_wdata.fill = (cur.fill == CNT_W'(HISTORY_DEPTH)) ? cur.fill :
					cur.fill + CNT_W'(1);
			end
			default: begin
				ws_wdata = cur;
			end
		endcase
	end

	assign ws_we    = (st_q == ST_LOAD) && (item_q.opcode != OP_QUERY);
	assign ps_we    = (st_q == ST_LOAD) && (item_q.opcode == OP_CAPTURE);
	assign ps_waddr = {wsel, cur.wp};
	assign ps_wdata = {cur.ovf, item_q.capture_value};
	assign ps_raddr = {wsel, idx_q};

	always_comb begin
		priority if (item_q.window_count == 7'd0) begin
			win_n = CNT_W'(1);
		end else if (item_q.window_count > 7'(HISTORY_DEPTH)) begin
			win_n = CNT_W'(HISTORY_DEPTH);
		end else begin
			win_n = CNT_W'(item_q.window_count);
		end
	end

	assign issue   = (st_q == ST_SUM) && (issue_cnt_q != n_q);
	assign sum_end = (st_q == ST_SUM) && !issue && !rd_vld_s1;

	wpca_ram #(
		.WIDTH (WS_W),
		.DEPTH (WHEELS)
	) u_wstate_ram (
		.clk   (clk),
		.we    (ws_we),
		.waddr (wsel),
		.wdata (ws_wdata),
		.raddr (WHL_W'(item.wheel)),
		.rdata (ws_rdata)
	);

	wpca_ram #(
		.WIDTH (32),
		.DEPTH (PS_DEPTH)
	) u_period_ram (
		.clk   (clk),
		.we    (ps_we),
		.waddr (ps_waddr),
		.wdata (ps_wdata),
		.raddr (ps_raddr),
		.rdata (ps_rdata)
	);

	wpca_div #(
		.DVD_W (SUM_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sum_end),
		.dividend (sum_q),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ws_vld_q    <= '0;
			done_q      <= 1'b0;
			rd_vld_s1   <= 1'b0;
			issue_cnt_q <= '0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= issue;
			if (ws_we) begin
				ws_vld_q[wsel] <= 1'b1;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept && item_ok) begin
						st_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					issue_cnt_q <= '0;
					st_q <= (item_q.opcode == OP_QUERY) ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					if (issue) begin
						issue_cnt_q <= issue_cnt_q + CNT_W'(1);
					end
					if (sum_end) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						done_q <= 1'b1;
						st_q   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if ((st_q == ST_LOAD) && (item_q.opcode == OP_QUERY)) begin
			tick_q <= cur.tick;
			fill_q <= cur.fill;
			n_q    <= win_n;
			sum_q  <= '0;
			// newest entry sits just below the write pointer
			idx_q  <= (cur.wp == '0) ? IDX_W'(HISTORY_DEPTH - 1) : cur.wp - IDX_W'(1);
		end else begin
			if (issue) begin
				idx_q <= (idx_q == '0) ? IDX_W'(HISTORY_DEPTH - 1) : idx_q - IDX_W'(1);
			end
			if (rd_vld_s1) begin
				sum_q <= sum_q + SUM_W'(ent_ok_s1 ? ps_rdata : STORE_RESET);
			end
		end
		ent_ok_s1 <= CNT_W'(idx_q) < fill_q;
		if (div_done) begin
			result_q.tick_total  <= tick_q;
			result_q.mean_period <= div_quo[31:0];
		end
	end

	assign busy   = (st_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SUM) |-> (issue_cnt_q <= n_q))
		else $error("ring read count ran past the window");

	a_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SUM) |-> (n_q != '0))
		else $error("zero window reached the averaging pass");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_DIV))
		else $error("divider finished outside the divide phase");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(st_q == ST_DIV)))
		else $error("result beat without a finished query");
`endif

endmodule

>>> bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wpca_pkg::*;

	localparam int WHEELS = 4;
	localparam int DEPTH  = 8;
	localparam int RANDOM_BEATS = 900;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	in_item_t  item   = '0;
	logic      busy;
	logic      done;
	out_item_t result;

	wheel_period_capture_averager_unit #(
		.WHEELS(WHEELS),
		.HISTORY_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	// predicted per-wheel state
	logic [31:0] wheel_ticks [WHEELS];
	logic [15:0] wheel_ovf [WHEELS];
	int          ring_ptr [WHEELS];
	logic [31:0] period_ring [WHEELS][DEPTH];

	in_item_t    pending_beats[$];
	out_item_t   expected_readings[$];
	int          beats_taken = 0;
	int          fail_count = 0;
	int          useful_beats = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic queue_beat(input logic [1:0] op, input int w, input int cap, input int n);
		in_item_t it;
		it.opcode        = op;
		it.wheel         = w[1:0];
		it.capture_value = cap[15:0];
		it.window_count  = n[6:0];
		pending_beats.push_back(it);
		if (op != OP_UNUSED)
			useful_beats++;
	endtask

	task automatic advance_wheel_model(input in_item_t it);
		int          w;
		int          n;
		int          idx;
		logic [63:0] sum;
		out_item_t   r;
		w = int'(it.wheel);
		if (w >= WHEELS)
			return;
		case (it.opcode)
			OP_OVERFLOW: begin
				wheel_ovf[w] = wheel_ovf[w] + 16'd1;
			end
			OP_CAPTURE: begin
				period_ring[w][ring_ptr[w]] = {wheel_ovf[w], it.capture_value};
				wheel_ticks[w] = wheel_ticks[w] + 32'd1;
				wheel_ovf[w] = '0;
				ring_ptr[w] = (ring_ptr[w] + 1) % DEPTH;
			end
			OP_QUERY: begin
				n = int'(it.window_count);
				if (n == 0)
					n = 1;
				if (n > DEPTH)
					n = DEPTH;
				sum = '0;
				// newest entry sits just below the write pointer
				for (int i = 0; i < n; i++) begin
					idx = (ring_ptr[w] + DEPTH - 1 - i) % DEPTH;
					sum = sum + 64'(period_ring[w][idx]);
				end
				r.tick_total  = wheel_ticks[w];
				r.mean_period = 32'(sum / 64'(n));
				expected_readings.push_back(r);
			end
			default: ;
		endcase
	endtask

	// sender side: one nonblocking update of start and item per edge
	always @(posedge clk) begin : drive_beats
		logic     nxt_start;
		in_item_t nxt_item;
		int       idle_pct;
		nxt_start = start;
		nxt_item  = item;
		if (beats_taken < 300)
			idle_pct = 11;
		else if (beats_taken < 600)
			idle_pct = 72;
		else
			idle_pct = 0;
		if (arst_n) begin
			if (start && !busy) begin
				advance_wheel_model(item);
				beats_taken++;
				nxt_start = 1'b0;
			end
			if (!nxt_start && pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
				nxt_item  = pending_beats.pop_front();
				nxt_start = 1'b1;
			end
		end
		start <= nxt_start;
		item  <= nxt_item;
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && done) begin
			if (expected_readings.size() == 0) begin
				$error("result beat with no query waiting: tick_total %0h mean_period %0h",
					result.tick_total, result.mean_period);
				fail_count++;
			end else begin
				want = expected_readings.pop_front();
				if (result.tick_total !== want.tick_total) begin
					$error("tick_total: expected %0h, actual %0h", want.tick_total,
						result.tick_total);
					fail_count++;
				end
				if (result.mean_period !== want.mean_period) begin
					$error("mean_period: expected %0h, actual %0h", want.mean_period,
						result.mean_period);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		int w;
		int k;
		int n;
		int cap;
		int r;
		for (int i = 0; i < WHEELS; i++) begin
			wheel_ticks[i] = '0;
			wheel_ovf[i]   = OVF_RESET;
			ring_ptr[i]    = 0;
			for (int e = 0; e < DEPTH; e++)
				period_ring[i][e] = STORE_RESET;
		end

		// queries on fresh state, window zero and oversized windows
		queue_beat(OP_QUERY, 0, 'h0000, 0);
		queue_beat(OP_QUERY, 1, 'hFFFF, 64);
		queue_beat(OP_QUERY, 2, 'h5A5A, 9);
		// first capture picks up the reset overflow count, giving all ones
		queue_beat(OP_CAPTURE, 0, 'hFFFF, 127);
		queue_beat(OP_QUERY, 0, 'h0000, 1);
		queue_beat(OP_QUERY, 0, 'h0000, 8);
		// overflow count wraps to zero
		queue_beat(OP_OVERFLOW, 1, 'hFFFF, 64);
		queue_beat(OP_CAPTURE, 1, 'h0000, 0);
		queue_beat(OP_QUERY, 1, 'h0000, 2);
		// unused opcode leaves everything alone
		queue_beat(OP_UNUSED, 2, 'hFFFF, 127);
		queue_beat(OP_QUERY, 2, 'hFFFF, 127);
		queue_beat(OP_OVERFLOW, 3, 'h0000, 0);
		queue_beat(OP_OVERFLOW, 3, 'h0000, 0);
		queue_beat(OP_CAPTURE, 3, 'h1234, 5);
		queue_beat(OP_QUERY, 3, 'h0000, 0);
		queue_beat(OP_QUERY, 3, 'hFFFF, 65);
		queue_beat(OP_CAPTURE, 0, 'h0000, 64);
		queue_beat(OP_QUERY, 0, 'h0000, 2);

		useful_beats = 0;
		while (useful_beats < RANDOM_BEATS) begin
			if ($urandom_range(99) < 12) begin
				// noise: any opcode, any field
				queue_beat(2'($urandom_range(3)), $urandom_range(3),
					$urandom_range(16'hFFFF), $urandom_range(127));
			end else begin
				// overflows, a capture, then maybe a query, mostly on that wheel
				w = $urandom_range(WHEELS - 1);
				if ($urandom_range(99) < 3)
					k = $urandom_range(300);
				else
					k = $urandom_range(3);
				for (int j = 0; j < k; j++)
					queue_beat(OP_OVERFLOW, w, $urandom_range(16'hFFFF), $urandom_range(127));
				r = $urandom_range(9);
				if (r == 0)
					cap = 0;
				else if (r == 1)
					cap = 'hFFFF;
				else
					cap = $urandom_range(16'hFFFF);
				queue_beat(OP_CAPTURE, w, cap, $urandom_range(127));
				if ($urandom_range(99) < 45) begin
					r = $urandom_range(99);
					if (r < 70)
						n = $urandom_range(9);
					else if (r < 85)
						n = $urandom_range(64, 10);
					else
						n = $urandom_range(127, 65);
					queue_beat(OP_QUERY, $urandom_range(99) < 80 ? w : $urandom_range(3),
						$urandom_range(16'hFFFF), n);
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || start)
			@(posedge clk);
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);

		if (fail_count == 0 && expected_readings.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
